// ===== design/assert_macros.svh =====
// Assertion helpers shared by the checker's modules.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== design/cfc_pkg.sv =====
package cfc_pkg;

	localparam logic [31:0] CRC_POLY       = 32'h04C11DB7;
	localparam logic [31:0] CRC_SEED_RST   = 32'hFFFFFFFF;
	localparam logic [7:0]  START_BYTE_RST = 8'h50;
	localparam int          CRC_BYTES      = 4;

	typedef enum logic [0:0] {
		CFG_START_BYTE = 1'b0,
		CFG_CRC_SEED   = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_START = 2'd1,
		ST_BAD_CRC   = 2'd2
	} status_t;

	typedef struct packed {
		logic start;
		logic hdr_good;
	} op_flags_t;

	// Folds one word into the CRC and clocks it 32 times, MSB first.
	// This flattens into a fixed XOR matrix.
	function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] word);
		logic [31:0] c;
		c = crc ^ word;
		for (int k = 0; k < 32; k++) begin
			c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ===== design/cfc_front.sv =====
module cfc_front #(
	parameter int FRAME_BYTES = 16,
	parameter int PW = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          rx_byte,
	input  logic                frame_start,
	input  logic [7:0]          start_byte,
	input  logic                q_full,
	output logic                push,
	output logic [7:0]          op_byte,
	output logic [PW-1:0]       op_pos,
	output cfc_pkg::op_flags_t  op_flags
);
	import cfc_pkg::*;

	localparam logic [PW-1:0] LAST_POS = PW'(FRAME_BYTES - 1);

	logic          in_frame_q;
	logic          hdr_q;
	logic [PW-1:0] pos_q;
	logic          accept;
	logic          hdr_now;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign hdr_now  = (rx_byte == start_byte);

	assign push              = accept && (frame_start || in_frame_q);
	assign op_byte           = rx_byte;
	assign op_pos            = frame_start ? '0 : pos_q;
	assign op_flags.start    = frame_start;
	assign op_flags.hdr_good = frame_start ? hdr_now : hdr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			hdr_q      <= 1'b0;
			pos_q      <= '0;
		end else if (accept) begin
			if (frame_start) begin
				in_frame_q <= 1'b1;
				hdr_q      <= hdr_now;
				pos_q      <= PW'(1);
			end else if (in_frame_q) begin
				if (pos_q == LAST_POS) begin
					in_frame_q <= 1'b0;
					pos_q      <= '0;
				end else begin
					pos_q <= pos_q + PW'(1);
				end
			end
		end
	end

endmodule

// ===== design/cfc_queue.sv =====
`include "assert_macros.svh"

module cfc_queue #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty,
	output logic             full
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`ASSERT_NEVER(a_queue_overflow, push && full, "Queue written while full.")
	`ASSERT_NEVER(a_queue_underflow, pop && empty, "Queue read while empty.")
	`ASSERT_CLK(a_queue_bound, count_q <= CW'(DEPTH), "Queue count exceeds depth.")

endmodule

// ===== design/cfc_back.sv =====
`include "assert_macros.svh"

module cfc_back #(
	parameter int FRAME_BYTES = 16,
	parameter int PW = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  logic [7:0]          op_byte,
	input  logic [PW-1:0]       op_pos,
	input  cfc_pkg::op_flags_t  op_flags,
	input  logic [31:0]         crc_seed,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic                frame_ok,
	output cfc_pkg::status_t    status,
	output logic [31:0]         computed_crc,
	output logic [31:0]         carried_crc,
	output logic [63:0]         payload_low,
	output logic [23:0]         payload_high
);
	import cfc_pkg::*;

	localparam int CRC_REGION = FRAME_BYTES - CRC_BYTES;
	localparam logic [PW-1:0] LAST_POS    = PW'(FRAME_BYTES - 1);
	localparam logic [PW-1:0] CRC_POS     = PW'(CRC_REGION);
	localparam logic [PW-1:0] CRC_END_POS = PW'(CRC_REGION - 1);

	logic [31:0]   crc_q;
	logic [23:0]   gather_q;
	logic [63:0]   lo_q;
	logic [23:0]   hi_q;
	logic [23:0]   recv_q;
	logic          out_valid_q;

	logic          is_last;
	logic          in_crc;
	logic          word_end;
	logic [6:0]    pos_w;
	logic [PW-1:0] rel_pos;
	logic [31:0]   crc_base;
	logic [23:0]   gather_base;
	logic [63:0]   lo_base;
	logic [23:0]   hi_base;
	logic [23:0]   recv_base;
	logic [31:0]   word;
	logic [31:0]   crc_n;
	logic [23:0]   gather_n;
	logic [63:0]   lo_n;
	logic [23:0]   hi_n;
	logic [31:0]   recv_n;
	status_t       status_n;

	assign is_last  = (op_pos == LAST_POS);
	assign pop      = q_valid && (!is_last || !out_valid_q || m_tready);
	assign in_crc   = (op_pos < CRC_POS);
	assign word_end = (op_pos[1:0] == 2'd3) || (op_pos == CRC_END_POS);
	assign pos_w    = 7'(op_pos);
	assign rel_pos  = op_pos - CRC_POS;

	always_comb begin
		crc_base    = op_flags.start ? crc_seed : crc_q;
		gather_base = op_flags.start ? '0 : gather_q;
		lo_base     = op_flags.start ? '0 : lo_q;
		hi_base     = op_flags.start ? '0 : hi_q;
		recv_base   = op_flags.start ? '0 : recv_q;

		word = {8'h00, gather_base};
		for (int k = 0; k < 4; k++) begin
			if (op_pos[1:0] == 2'(k)) begin
				word[8*k +: 8] = op_byte;
			end
		end

		crc_n    = (in_crc && word_end) ? crc_word(crc_base, word) : crc_base;
		gather_n = in_crc ? (word_end ? 24'h000000 : word[23:0]) : gather_base;

		lo_n = lo_base;
		for (int k = 0; k < 8; k++) begin
			if (in_crc && pos_w == 7'(k + 1)) begin
				lo_n[8*k +: 8] = op_byte;
			end
		end
		hi_n = hi_base;
		for (int k = 0; k < 3; k++) begin
			if (in_crc && pos_w == 7'(k + 9)) begin
				hi_n[8*k +: 8] = op_byte;
			end
		end

		recv_n = {8'h00, recv_base};
		for (int k = 0; k < 4; k++) begin
			if (!in_crc && rel_pos[1:0] == 2'(k)) begin
				recv_n[8*k +: 8] = op_byte;
			end
		end

		if (!op_flags.hdr_good) begin
			status_n = ST_BAD_START;
		end else if (crc_n != recv_n) begin
			status_n = ST_BAD_CRC;
		end else begin
			status_n = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			crc_q    <= crc_n;
			gather_q <= gather_n;
			lo_q     <= lo_n;
			hi_q     <= hi_n;
			recv_q   <= recv_n[23:0];
		end
		if (pop && is_last) begin
			frame_ok     <= (status_n == ST_OK);
			status       <= status_n;
			computed_crc <= crc_n;
			carried_crc  <= recv_n;
			payload_low  <= lo_n;
			payload_high <= hi_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && is_last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

	`ASSERT_CLK(a_start_at_zero, pop && op_flags.start |-> op_pos == '0, "Start beat not at byte zero.")
	`ASSERT_CLK(a_last_gives_result, pop && is_last |=> out_valid_q, "Last byte gave no result.")

endmodule

// ===== design/crc_frame_checker_unit.sv =====
// CRC frame checker.
// Receive bytes arrive on the s_ stream, one byte per beat: s_tdata[7:0] is the
// byte and s_tuser[0] flags byte zero of a frame. Frames are FRAME_BYTES long.
// Bytes that arrive outside a frame are dropped, and a new start flag abandons
// any partial frame without a result.
// On the last byte of each frame one verdict beat goes out on the m_ stream with
// the status, both CRCs and the raw payload bytes 1 to 11.
// The front end takes one byte per cycle into a small queue unless it is full; the back
// end drains one entry per cycle, stalling only at a frame's last byte while a verdict
// waits, and folds each completed 32-bit word into the CRC as it pops the word's last
// byte. Sustained rate is one byte per cycle while m_tready stays high. With the queue
// empty, the last byte passes the queue and the output register before m_tvalid rises.
// When m_tready is low the verdict holds in its output register; the back end keeps
// working on further bytes of the next frame and stops only at that frame's last
// byte, and the front end stops only once the queue is full.
// Reset empties the queue, closes any open frame and restores start_byte to 0x50
// and crc_seed to all ones. Registers are written through cfg_we, cfg_index and cfg_data;
// the user writes them only while the block is idle, which the block does not enforce.
module crc_frame_checker_unit #(
	parameter int FRAME_BYTES = 16,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,    // [7:0] rx_byte
	input  logic [0:0]    s_tuser,    // [0] frame_start
	output logic          m_tvalid,
	input  logic          m_tready,
	// [31:0] computed_crc, [63:32] carried_crc, [127:64] payload_low, [151:128] payload_high
	output logic [151:0]  m_tdata,
	output logic [2:0]    m_tuser,    // [0] frame_ok, [2:1] status
	input  logic          cfg_we,
	input  logic [0:0]    cfg_index,
	input  logic [31:0]   cfg_data
);
	import cfc_pkg::*;

	localparam int PW = $clog2(FRAME_BYTES);
	localparam int QW = 8 + PW + $bits(op_flags_t);

	logic [7:0]    start_byte_q;
	logic [31:0]   crc_seed_q;

	logic          q_full;
	logic          q_empty;
	logic          push;
	logic          pop;
	logic [7:0]    f_byte;
	logic [PW-1:0] f_pos;
	op_flags_t     f_flags;
	logic [QW-1:0] q_rd;
	logic [7:0]    b_byte;
	logic [PW-1:0] b_pos;
	op_flags_t     b_flags;

	logic          frame_ok;
	status_t       status;
	logic [31:0]   computed_crc;
	logic [31:0]   carried_crc;
	logic [63:0]   payload_low;
	logic [23:0]   payload_high;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
			crc_seed_q   <= CRC_SEED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_BYTE: begin
					start_byte_q <= cfg_data[7:0];
				end
				CFG_CRC_SEED: begin
					crc_seed_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	cfc_front #(
		.FRAME_BYTES (FRAME_BYTES),
		.PW          (PW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.rx_byte     (s_tdata),
		.frame_start (s_tuser[0]),
		.start_byte  (start_byte_q),
		.q_full      (q_full),
		.push        (push),
		.op_byte     (f_byte),
		.op_pos      (f_pos),
		.op_flags    (f_flags)
	);

	cfc_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data ({f_flags, f_pos, f_byte}),
		.pop     (pop),
		.rd_data (q_rd),
		.empty   (q_empty),
		.full    (q_full)
	);

	assign {b_flags, b_pos, b_byte} = q_rd;

	cfc_back #(
		.FRAME_BYTES (FRAME_BYTES),
		.PW          (PW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (!q_empty),
		.op_byte      (b_byte),
		.op_pos       (b_pos),
		.op_flags     (b_flags),
		.crc_seed     (crc_seed_q),
		.pop          (pop),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.frame_ok     (frame_ok),
		.status       (status),
		.computed_crc (computed_crc),
		.carried_crc  (carried_crc),
		.payload_low  (payload_low),
		.payload_high (payload_high)
	);

	assign m_tdata = {payload_high, payload_low, carried_crc, computed_crc};
	assign m_tuser = {status, frame_ok};

endmodule
